// File: rtl/mfmc_pkg.sv
// Shared types, constants and helper functions for the median-filtered motor
// command unit. No dependencies.
`timescale 1ns / 1ps

package mfmc_pkg;

    // converter sample width, 8 to 16
    localparam int SAMPLE_BITS = 12;

    localparam int DIR_THR_BITS = 12;
    localparam int GAIN_BITS    = 18;
    localparam int OFFSET_BITS  = 16;
    localparam int GAIN_FRAC    = 16;
    localparam int SERVO_BITS   = 16;
    localparam int PINS_BITS    = 3;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 18;

    // wide enough to hold a sample and a direction threshold
    localparam int THR_CMP_BITS = (SAMPLE_BITS > DIR_THR_BITS) ? SAMPLE_BITS : DIR_THR_BITS;
    // wide enough to hold a sample and the top speed band edge
    localparam int SPEED_CMP_BITS = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
    localparam int SCALED_BITS = PROD_BITS - GAIN_FRAC;
    localparam int SUM_BITS    = ((SCALED_BITS > OFFSET_BITS) ? SCALED_BITS : OFFSET_BITS) + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIR_LEFT_BELOW = 2'd0,
        CFG_DIR_RIGHT_FROM = 2'd1,
        CFG_SERVO_GAIN     = 2'd2,
        CFG_SERVO_OFFSET   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DIR_THR_BITS-1:0] dir_left_below;
        logic [DIR_THR_BITS-1:0] dir_right_from;
        logic [GAIN_BITS-1:0]    servo_gain_q16;
        logic [OFFSET_BITS-1:0]  servo_offset;
    } cfg_t;

    localparam logic [DIR_THR_BITS-1:0] DIR_LEFT_BELOW_RST = DIR_THR_BITS'(1850);
    localparam logic [DIR_THR_BITS-1:0] DIR_RIGHT_FROM_RST = DIR_THR_BITS'(2250);
    localparam logic [GAIN_BITS-1:0]    SERVO_GAIN_RST     = GAIN_BITS'(119931);
    localparam logic [OFFSET_BITS-1:0]  SERVO_OFFSET_RST   = OFFSET_BITS'(7000);

    localparam logic [SPEED_CMP_BITS-1:0] SPEED_BAND_1 = SPEED_CMP_BITS'(800);
    localparam logic [SPEED_CMP_BITS-1:0] SPEED_BAND_2 = SPEED_CMP_BITS'(1600);
    localparam logic [SPEED_CMP_BITS-1:0] SPEED_BAND_3 = SPEED_CMP_BITS'(2400);
    localparam logic [SPEED_CMP_BITS-1:0] SPEED_BAND_4 = SPEED_CMP_BITS'(3200);

    // MS3..MS1 pin patterns
    localparam logic [PINS_BITS-1:0] PINS_SIXTEENTH = 3'd7;
    localparam logic [PINS_BITS-1:0] PINS_EIGHTH    = 3'd3;
    localparam logic [PINS_BITS-1:0] PINS_QUARTER   = 3'd2;
    localparam logic [PINS_BITS-1:0] PINS_HALF      = 3'd1;
    localparam logic [PINS_BITS-1:0] PINS_FULL      = 3'd0;

    localparam logic [SERVO_BITS-1:0] SERVO_MAX = '1;

    function automatic logic [PINS_BITS-1:0] pins_for_speed(input logic [SAMPLE_BITS-1:0] s);
        logic [SPEED_CMP_BITS-1:0] sx;
        sx = SPEED_CMP_BITS'(s);
        if (sx < SPEED_BAND_1)      return PINS_SIXTEENTH;
        else if (sx < SPEED_BAND_2) return PINS_EIGHTH;
        else if (sx < SPEED_BAND_3) return PINS_QUARTER;
        else if (sx < SPEED_BAND_4) return PINS_HALF;
        else                        return PINS_FULL;
    endfunction

endpackage

// File: rtl/mfmc_cfg_regs.sv
// Configuration register file: thresholds, servo gain and offset.
// Depends on mfmc_pkg.
`timescale 1ns / 1ps

module mfmc_cfg_regs import mfmc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIR_LEFT_BELOW: cfg_next.dir_left_below = cfg_data[DIR_THR_BITS-1:0];
                CFG_DIR_RIGHT_FROM: cfg_next.dir_right_from = cfg_data[DIR_THR_BITS-1:0];
                CFG_SERVO_GAIN:     cfg_next.servo_gain_q16 = cfg_data[GAIN_BITS-1:0];
                CFG_SERVO_OFFSET:   cfg_next.servo_offset   = cfg_data[OFFSET_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dir_left_below <= DIR_LEFT_BELOW_RST;
            cfg_reg.dir_right_from <= DIR_RIGHT_FROM_RST;
            cfg_reg.servo_gain_q16 <= SERVO_GAIN_RST;
            cfg_reg.servo_offset   <= SERVO_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/mfmc_median3.sv
// One channel of the median-of-three filter with its two-sample history.
// Depends on mfmc_pkg.
`timescale 1ns / 1ps

module mfmc_median3 import mfmc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] x,
    output logic [SAMPLE_BITS-1:0] med
);

    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS-1:0] older_reg;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] cap;

    always_comb begin
        lo  = (x < prev_reg) ? x : prev_reg;
        hi  = (x < prev_reg) ? prev_reg : x;
        cap = (hi < older_reg) ? hi : older_reg;
        med = (lo > cap) ? lo : cap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            older_reg <= '0;
        end else if (shift_en) begin
            older_reg <= prev_reg;
            prev_reg  <= x;
        end
    end

endmodule

// File: rtl/mfmc_cmd.sv
// Command decode: microstep pins, direction with dead band, servo compare.
// Purely combinational; depends on mfmc_pkg.
`timescale 1ns / 1ps

module mfmc_cmd import mfmc_pkg::*; (
    input  cfg_t                   cfg,
    input  logic [SAMPLE_BITS-1:0] speed,
    input  logic [SAMPLE_BITS-1:0] dir,
    input  logic [SAMPLE_BITS-1:0] pos,
    input  logic                   held,
    output logic [PINS_BITS-1:0]   pins,
    output logic                   held_new,
    output logic                   run,
    output logic [SERVO_BITS-1:0]  servo
);

    logic [THR_CMP_BITS-1:0] dir_x;
    logic                    go_left;
    logic                    go_right;
    logic [PROD_BITS-1:0]    prod;
    logic [SCALED_BITS-1:0]  scaled;
    logic [SUM_BITS-1:0]     sum;

    always_comb begin
        pins = pins_for_speed(speed);

        // right wins when the thresholds overlap
        dir_x    = THR_CMP_BITS'(dir);
        go_left  = dir_x < THR_CMP_BITS'(cfg.dir_left_below);
        go_right = dir_x >= THR_CMP_BITS'(cfg.dir_right_from);
        run      = go_left | go_right;
        if (go_right)     held_new = 1'b1;
        else if (go_left) held_new = 1'b0;
        else              held_new = held;

        prod   = PROD_BITS'(pos) * PROD_BITS'(cfg.servo_gain_q16);
        scaled = prod[PROD_BITS-1:GAIN_FRAC];
        sum    = SUM_BITS'(scaled) + SUM_BITS'(cfg.servo_offset);
        servo  = (sum[SUM_BITS-1:SERVO_BITS] != '0) ? SERVO_MAX : sum[SERVO_BITS-1:0];
    end

endmodule

// File: rtl/median_filtered_motor_command_unit.sv
// Top level: input register, three median filters, command decode, result register.
// Depends on mfmc_pkg, mfmc_cfg_regs, mfmc_median3, mfmc_cmd.
//
//  channel | ports                 | direction | beat
//  s_      | s_valid / s_ready     | in        | speed, dir, pos samples
//  m_      | m_valid / m_ready     | out       | filtered samples, pins, dir, servo
//  cfg_    | cfg_valid / cfg_ready | in        | register index and data
//
// One beat per cycle sustained while m_ready is high; m_valid rises after an s_ beat passes
// through the input register, then the filters and decode into the result register.
// Filter history and held direction advance as an item enters the result register.
// A stalled m_ side holds the result; one more input beat is taken into the
// input register. Reset clears history, held direction and both valid flags.
`timescale 1ns / 1ps

module median_filtered_motor_command_unit import mfmc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_speed_sample,
    input  logic [SAMPLE_BITS-1:0]   s_dir_sample,
    input  logic [SAMPLE_BITS-1:0]   s_pos_sample,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SAMPLE_BITS-1:0]   m_filtered_speed,
    output logic [SAMPLE_BITS-1:0]   m_filtered_dir,
    output logic [SAMPLE_BITS-1:0]   m_filtered_pos,
    output logic [PINS_BITS-1:0]     m_microstep_pins,
    output logic                     m_turn_right,
    output logic                     m_step_run,
    output logic [SERVO_BITS-1:0]    m_servo_compare,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t cfg;

    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic [SAMPLE_BITS-1:0] a_speed_reg;
    logic [SAMPLE_BITS-1:0] a_dir_reg;
    logic [SAMPLE_BITS-1:0] a_pos_reg;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [SAMPLE_BITS-1:0] speed_reg;
    logic [SAMPLE_BITS-1:0] dir_reg;
    logic [SAMPLE_BITS-1:0] pos_reg;
    logic [PINS_BITS-1:0]   pins_reg;
    logic                   run_reg;
    logic [SERVO_BITS-1:0]  servo_reg;
    logic                   held_reg;

    logic                   s_accept;
    logic                   advance;

    logic [SAMPLE_BITS-1:0] med_speed;
    logic [SAMPLE_BITS-1:0] med_dir;
    logic [SAMPLE_BITS-1:0] med_pos;
    logic [PINS_BITS-1:0]   pins_c;
    logic                   held_c;
    logic                   run_c;
    logic [SERVO_BITS-1:0]  servo_c;

    mfmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // item moves from the input register into the result register
    assign advance  = a_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~a_valid_reg | advance;
    assign s_accept = s_valid & s_ready;

    mfmc_median3 u_med_speed (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (advance),
        .x        (a_speed_reg),
        .med      (med_speed)
    );

    mfmc_median3 u_med_dir (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (advance),
        .x        (a_dir_reg),
        .med      (med_dir)
    );

    mfmc_median3 u_med_pos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (advance),
        .x        (a_pos_reg),
        .med      (med_pos)
    );

    mfmc_cmd u_cmd (
        .cfg      (cfg),
        .speed    (med_speed),
        .dir      (med_dir),
        .pos      (med_pos),
        .held     (held_reg),
        .pins     (pins_c),
        .held_new (held_c),
        .run      (run_c),
        .servo    (servo_c)
    );

    always_comb begin
        if (s_accept)     a_valid_next = 1'b1;
        else if (advance) a_valid_next = 1'b0;
        else              a_valid_next = a_valid_reg;

        if (advance)      m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            held_reg    <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            if (advance) begin
                held_reg <= held_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_speed_reg <= s_speed_sample;
            a_dir_reg   <= s_dir_sample;
            a_pos_reg   <= s_pos_sample;
        end
        if (advance) begin
            speed_reg <= med_speed;
            dir_reg   <= med_dir;
            pos_reg   <= med_pos;
            pins_reg  <= pins_c;
            run_reg   <= run_c;
            servo_reg <= servo_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_speed = speed_reg;
    assign m_filtered_dir   = dir_reg;
    assign m_filtered_pos   = pos_reg;
    assign m_microstep_pins = pins_reg;
    assign m_turn_right     = held_reg;
    assign m_step_run       = run_reg;
    assign m_servo_compare  = servo_reg;

endmodule

// File: rtl/mfmc_checker.sv
// Port-level checks for the motor command unit, attached by bind.
// Depends on mfmc_pkg and median_filtered_motor_command_unit.
`timescale 1ns / 1ps

module mfmc_checker import mfmc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_filtered_speed,
    input logic [PINS_BITS-1:0]   m_microstep_pins,
    input logic                   m_turn_right,
    input logic                   m_step_run,
    input logic [SERVO_BITS-1:0]  m_servo_compare
);

    logic [SPEED_CMP_BITS-1:0] speed_x;

    assign speed_x = SPEED_CMP_BITS'(m_filtered_speed);

    // no result left over from before reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // stalled beat holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_speed)
            && $stable(m_microstep_pins) && $stable(m_turn_right)
            && $stable(m_step_run) && $stable(m_servo_compare))
        else $error("result changed while stalled");

    // slow band selects sixteenth stepping
    a_pins_slow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && speed_x < SPEED_BAND_1 |-> m_microstep_pins == PINS_SIXTEENTH)
        else $error("pins wrong in slow band");

    // fast band selects full stepping
    a_pins_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && speed_x >= SPEED_BAND_4 |-> m_microstep_pins == PINS_FULL)
        else $error("pins wrong in fast band");

endmodule

bind median_filtered_motor_command_unit mfmc_checker u_mfmc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filtered_speed (m_filtered_speed),
    .m_microstep_pins (m_microstep_pins),
    .m_turn_right     (m_turn_right),
    .m_step_run       (m_step_run),
    .m_servo_compare  (m_servo_compare)
);
